[hw/rtl/tplea_pkg.sv]
// Package for the two-pool line extent allocator: sizes, codes and payload types.
`default_nettype none
package tplea_pkg;
    localparam int FAST_LINES   = 4096;
    localparam int SLOW_LINES   = 1048576;
    localparam int MAX_EXTENTS  = 16;
    localparam int IDX_W        = $clog2(MAX_EXTENTS);
    localparam int HDR_LEAD_ODD  = 3;
    localparam int HDR_TAIL_EVEN = 2;
    localparam int HDR_TAIL      = 2;
    localparam int COMMON_LINES = HDR_LEAD_ODD + HDR_TAIL_EVEN + 2 * HDR_TAIL;
    localparam int ODD_RED  = HDR_LEAD_ODD + HDR_TAIL;
    localparam int EVEN_RED = HDR_TAIL_EVEN + HDR_TAIL;

    // Pool-independent working width; holds any slow line plus a count.
    localparam int LW = 23;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NO_SPACE   = 3'd1,
        ST_BAD_START  = 3'd2,
        ST_OVERFLOW   = 3'd3,
        ST_TABLE_FULL = 3'd4
    } status_t;

    localparam logic CFG_FAST_BASE = 1'b0;
    localparam logic CFG_SLOW_BASE = 1'b1;

    typedef struct packed {
        logic [1:0]  op;
        logic [20:0] line_count;
        logic [11:0] free_fast_start;
        logic [12:0] free_fast_count;
        logic [19:0] free_slow_start;
        logic [20:0] free_slow_count;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [11:0] fast_start;
        logic [12:0] fast_count;
        logic [19:0] slow_start;
        logic [20:0] slow_count;
        logic [20:0] done_count;
    } rsp_t;
endpackage
`default_nettype wire

[hw/rtl/two_pool_line_extent_allocator.sv]
// Top level of the two-pool line extent allocator: sequencer and scan over both tables.
//
//  channel | direction | handshake      | payload
//  req     | in        | req_valid/stall| tplea_pkg::req_t
//  rsp     | out       | rsp_valid/stall| tplea_pkg::rsp_t
//  cfg     | in        | cfg_we         | cfg_index, cfg_data (20 bits)
//
// An allocate or a free walks one table entry a cycle through the single entry comparator:
// the request passes through set-up, the scan of all 16 entries, decision, update and output,
// and an allocate that falls back to the slow pool scans the table again after its decision.
// A clear, a zero-count allocate or free, a rejected free and an unused op go from set-up to output.
// Reset clears the valid bits, free totals, bases and sequencer; entries need none.
// The result waits in an output register while rsp_stall is high; the next request is
// taken in the cycle after the result transfer at the earliest.
`default_nettype none
module two_pool_line_extent_allocator (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_stall,
    input  wire tplea_pkg::req_t   req,
    output logic                   rsp_valid,
    input  wire logic              rsp_stall,
    output tplea_pkg::rsp_t        rsp,
    input  wire logic              cfg_we,
    input  wire logic              cfg_index,
    input  wire logic [19:0]       cfg_data
);
    localparam int LW = tplea_pkg::LW;
    localparam int IW = tplea_pkg::IDX_W;
    localparam int N  = tplea_pkg::MAX_EXTENTS;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SETUP = 6'b000010,
        S_SCAN  = 6'b000100,
        S_DEC   = 6'b001000,
        S_UPD   = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [11:0] fast_base_reg;
    logic [19:0] slow_base_reg;
    logic [LW-1:0] fast_vbase_reg, slow_vbase_reg;
    logic [LW-1:0] fast_total_reg, slow_total_reg;

    // Extent tables: one pool bit selects the row group.
    logic [LW-1:0] ext_start_reg [2][N];
    logic [LW-1:0] ext_len_reg   [2][N];
    logic [N-1:0]  ext_valid_reg [2];

    tplea_pkg::req_t req_reg;
    tplea_pkg::rsp_t rsp_reg;
    logic rsp_valid_reg;

    logic          pool_reg;      // 0 fast, 1 slow
    logic [LW-1:0] cnt_reg;       // count of the current pool operation
    logic [LW-1:0] fstart_reg;    // free start
    logic [IW:0]   idx_reg;
    logic          pick_ok_reg, left_ok_reg, right_ok_reg, slot_ok_reg;
    logic [IW-1:0] pick_reg, left_reg, right_reg, slot_reg;
    logic [LW-1:0] pick_start_reg;

    logic [IW-1:0] idx;
    logic [LW-1:0] e_start, e_len, e_end, f_end, lines, vbase, total;
    logic          e_valid;
    logic [LW-1:0] e_len_p, l_len, r_len;
    logic [LW-1:0] new_fast_vbase;
    logic          fast_fits;

    assign idx     = idx_reg[IW-1:0];
    assign e_start = ext_start_reg[pool_reg][idx];
    assign e_len   = ext_len_reg[pool_reg][idx];
    assign e_valid = ext_valid_reg[pool_reg][idx];
    assign e_end   = e_start + e_len;
    assign f_end   = fstart_reg + cnt_reg;
    assign lines   = pool_reg ? LW'(tplea_pkg::SLOW_LINES) : LW'(tplea_pkg::FAST_LINES);
    assign vbase   = pool_reg ? slow_vbase_reg : fast_vbase_reg;
    assign total   = pool_reg ? slow_total_reg : fast_total_reg;
    assign e_len_p = ext_len_reg[pool_reg][pick_reg];
    assign l_len   = ext_len_reg[pool_reg][left_reg];
    assign r_len   = ext_len_reg[pool_reg][right_reg];

    // The fast pool keeps its shared header lines ahead of the first allocatable line.
    assign new_fast_vbase = LW'(fast_base_reg) + LW'(tplea_pkg::COMMON_LINES);
    assign fast_fits      = new_fast_vbase < LW'(tplea_pkg::FAST_LINES);

    logic [LW-1:0] red;
    assign red = req_reg.line_count[0] ? LW'(tplea_pkg::ODD_RED) : LW'(tplea_pkg::EVEN_RED);

    logic [LW-1:0] maxc;
    assign maxc = (vbase >= lines) ? '0 : lines - vbase;

    assign req_stall = (state_reg != S_IDLE) || rsp_valid_reg;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (req_valid && !req_stall) state_next = S_SETUP;
            S_SETUP: state_next = S_SCAN;
            S_SCAN:  if (idx_reg == (IW+1)'(N-1)) state_next = S_DEC;
            S_DEC:   state_next = S_UPD;
            S_UPD:   state_next = S_OUT;
            S_OUT:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            fast_base_reg  <= '0;
            slow_base_reg  <= '0;
            fast_vbase_reg <= '0;
            slow_vbase_reg <= '0;
            fast_total_reg <= '0;
            slow_total_reg <= '0;
            ext_valid_reg[0] <= '0;
            ext_valid_reg[1] <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == tplea_pkg::CFG_FAST_BASE)
                    fast_base_reg <= cfg_data[11:0];
                else
                    slow_base_reg <= cfg_data;
            end
            if (state_reg == S_OUT)
                rsp_valid_reg <= 1'b1;
            else if (rsp_valid_reg && !rsp_stall)
                rsp_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    state_reg <= state_next;
                    if (req_valid && !req_stall)
                    begin
                        req_reg  <= req;
                        rsp_reg  <= '0;
                        if (tplea_pkg::op_t'(req.op) == tplea_pkg::OP_FREE
                            && req.free_fast_count == '0)
                        begin
                            pool_reg   <= 1'b1;
                            cnt_reg    <= LW'(req.free_slow_count);
                            fstart_reg <= LW'(req.free_slow_start);
                        end
                        else if (tplea_pkg::op_t'(req.op) == tplea_pkg::OP_FREE)
                        begin
                            pool_reg   <= 1'b0;
                            cnt_reg    <= LW'(req.free_fast_count);
                            fstart_reg <= LW'(req.free_fast_start);
                        end
                        else
                        begin
                            pool_reg   <= 1'b0;
                            cnt_reg    <= LW'(req.line_count);
                            fstart_reg <= '0;
                        end
                    end
                end
                S_SETUP:
                begin
                    idx_reg     <= '0;
                    pick_ok_reg <= 1'b0;
                    left_ok_reg <= 1'b0;
                    right_ok_reg <= 1'b0;
                    slot_ok_reg <= 1'b0;
                    case (tplea_pkg::op_t'(req_reg.op))
                        tplea_pkg::OP_CLEAR:
                        begin
                            fast_vbase_reg <= new_fast_vbase;
                            slow_vbase_reg <= LW'(slow_base_reg);
                            ext_valid_reg[0] <= N'(fast_fits);
                            ext_valid_reg[1] <= N'(1'b1);
                            ext_start_reg[0][0] <= new_fast_vbase;
                            ext_len_reg[0][0]   <= LW'(tplea_pkg::FAST_LINES)
                                                   - new_fast_vbase;
                            fast_total_reg      <= fast_fits
                                                   ? LW'(tplea_pkg::FAST_LINES) - new_fast_vbase
                                                   : '0;
                            ext_start_reg[1][0] <= LW'(slow_base_reg);
                            ext_len_reg[1][0]   <= LW'(tplea_pkg::SLOW_LINES)
                                                   - LW'(slow_base_reg);
                            slow_total_reg      <= LW'(tplea_pkg::SLOW_LINES)
                                                   - LW'(slow_base_reg);
                            state_reg <= S_OUT;
                        end
                        tplea_pkg::OP_ALLOC:
                        begin
                            if (req_reg.line_count == '0)
                                state_reg <= S_OUT;
                            else
                                state_reg <= S_SCAN;
                        end
                        tplea_pkg::OP_FREE:
                        begin
                            if (cnt_reg == '0)
                                state_reg <= S_OUT;
                            else if (fstart_reg < vbase || fstart_reg >= lines)
                            begin
                                rsp_reg.status <= tplea_pkg::ST_BAD_START;
                                state_reg <= S_OUT;
                            end
                            else if (f_end > lines || cnt_reg + total > maxc)
                            begin
                                rsp_reg.status <= tplea_pkg::ST_OVERFLOW;
                                state_reg <= S_OUT;
                            end
                            else
                                state_reg <= S_SCAN;
                        end
                        default: state_reg <= S_OUT;
                    endcase
                end
                S_SCAN:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (tplea_pkg::op_t'(req_reg.op) == tplea_pkg::OP_ALLOC)
                    begin
                        if (e_valid && e_len >= cnt_reg
                            && (!pick_ok_reg || e_start < pick_start_reg))
                        begin
                            pick_ok_reg    <= 1'b1;
                            pick_reg       <= idx;
                            pick_start_reg <= e_start;
                        end
                    end
                    else if (!e_valid)
                    begin
                        if (!slot_ok_reg)
                        begin
                            slot_ok_reg <= 1'b1;
                            slot_reg    <= idx;
                        end
                    end
                    else if (!left_ok_reg && e_end == fstart_reg)
                    begin
                        left_ok_reg <= 1'b1;
                        left_reg    <= idx;
                    end
                    else if (!right_ok_reg && e_start == f_end)
                    begin
                        right_ok_reg <= 1'b1;
                        right_reg    <= idx;
                    end
                    state_reg <= state_next;
                end
                S_DEC:
                begin
                    if (tplea_pkg::op_t'(req_reg.op) == tplea_pkg::OP_ALLOC && !pick_ok_reg)
                    begin
                        // The fast pool failed: retry in the slow pool if the request allows.
                        if (!pool_reg && LW'(req_reg.line_count) > red)
                        begin
                            pool_reg    <= 1'b1;
                            cnt_reg     <= LW'(req_reg.line_count) - red;
                            idx_reg     <= '0;
                            pick_ok_reg <= 1'b0;
                            state_reg   <= S_SCAN;
                        end
                        else
                        begin
                            rsp_reg.status <= tplea_pkg::ST_NO_SPACE;
                            state_reg <= S_OUT;
                        end
                    end
                    else
                        state_reg <= S_UPD;
                end
                S_UPD:
                begin
                    state_reg <= S_OUT;
                    if (tplea_pkg::op_t'(req_reg.op) == tplea_pkg::OP_ALLOC)
                    begin
                        if (e_len_p == cnt_reg)
                            ext_valid_reg[pool_reg][pick_reg] <= 1'b0;
                        else
                        begin
                            ext_start_reg[pool_reg][pick_reg] <= pick_start_reg + cnt_reg;
                            ext_len_reg[pool_reg][pick_reg]   <= e_len_p - cnt_reg;
                        end
                        if (pool_reg)
                        begin
                            slow_total_reg <= (slow_total_reg >= cnt_reg)
                                              ? slow_total_reg - cnt_reg : '0;
                            rsp_reg.slow_start <= pick_start_reg[19:0];
                            rsp_reg.slow_count <= cnt_reg[20:0];
                        end
                        else
                        begin
                            fast_total_reg <= (fast_total_reg >= cnt_reg)
                                              ? fast_total_reg - cnt_reg : '0;
                            rsp_reg.fast_start <= pick_start_reg[11:0];
                            rsp_reg.fast_count <= cnt_reg[12:0];
                        end
                        rsp_reg.done_count <= cnt_reg[20:0];
                    end
                    else if (!left_ok_reg && !right_ok_reg && !slot_ok_reg)
                        rsp_reg.status <= tplea_pkg::ST_TABLE_FULL;
                    else
                    begin
                        if (left_ok_reg && right_ok_reg)
                        begin
                            ext_len_reg[pool_reg][left_reg] <= l_len + cnt_reg + r_len;
                            ext_valid_reg[pool_reg][right_reg] <= 1'b0;
                        end
                        else if (left_ok_reg)
                            ext_len_reg[pool_reg][left_reg] <= l_len + cnt_reg;
                        else if (right_ok_reg)
                        begin
                            ext_start_reg[pool_reg][right_reg] <= fstart_reg;
                            ext_len_reg[pool_reg][right_reg]   <= r_len + cnt_reg;
                        end
                        else
                        begin
                            ext_start_reg[pool_reg][slot_reg] <= fstart_reg;
                            ext_len_reg[pool_reg][slot_reg]   <= cnt_reg;
                            ext_valid_reg[pool_reg][slot_reg] <= 1'b1;
                        end
                        if (pool_reg)
                            slow_total_reg <= slow_total_reg + cnt_reg;
                        else
                            fast_total_reg <= fast_total_reg + cnt_reg;
                        rsp_reg.done_count <= cnt_reg[20:0];
                    end
                end
                S_OUT:
                begin
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // A result is only raised from the output step.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(state_reg) == S_OUT)
        else $error("result raised outside the output step");
    // No request is taken while a result waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> req_stall)
        else $error("request taken while a result waits");
    // The scan index never runs past the table.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> idx_reg < (IW+1)'(N))
        else $error("scan index out of range");
endmodule
`default_nettype wire

[tb/sv/tplea_checker.sv]
// Checker for the two-pool line extent allocator: predicts each result and compares it.
`default_nettype none
module tplea_checker (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    input  wire logic            req_stall,
    input  wire tplea_pkg::req_t req,
    input  wire logic            rsp_valid,
    input  wire logic            rsp_stall,
    input  wire tplea_pkg::rsp_t rsp,
    input  wire logic            cfg_we,
    input  wire logic            cfg_index,
    input  wire logic [19:0]     cfg_data,
    output int                   fail_count,
    output int                   pending,
    output int                   results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    // Working values are kept at 64 bits so that sums never wrap.
    typedef struct {
        longint unsigned st [tplea_pkg::MAX_EXTENTS];
        longint unsigned ln [tplea_pkg::MAX_EXTENTS];
        bit              vd [tplea_pkg::MAX_EXTENTS];
        longint unsigned total;
        longint unsigned base;
        longint unsigned lines;
    } pool_t;

    pool_t fast_pool;
    pool_t slow_pool;
    logic [11:0] fast_base_reg;
    logic [19:0] slow_base_reg;
    tplea_pkg::rsp_t expected_rsps[$];

    function automatic void load_pool(ref pool_t p, input longint unsigned base);
        for (int i = 0; i < tplea_pkg::MAX_EXTENTS; i++)
            p.vd[i] = 0;
        p.base  = base;
        p.total = 0;
        if (base < p.lines)
        begin
            p.st[0] = base;
            p.ln[0] = p.lines - base;
            p.vd[0] = 1;
            p.total = p.lines - base;
        end
    endfunction

    function automatic bit take_first_fit(ref pool_t p, input longint unsigned cnt,
                                          output longint unsigned grant);
        int pick;
        pick = -1;
        grant = 0;
        for (int i = 0; i < tplea_pkg::MAX_EXTENTS; i++)
            if (p.vd[i] && p.ln[i] >= cnt && (pick < 0 || p.st[i] < p.st[pick]))
                pick = i;
        if (pick < 0)
            return 0;
        grant = p.st[pick];
        p.total = (p.total >= cnt) ? p.total - cnt : 0;
        if (p.ln[pick] == cnt)
            p.vd[pick] = 0;
        else
        begin
            p.st[pick] += cnt;
            p.ln[pick] -= cnt;
        end
        return 1;
    endfunction

    function automatic tplea_pkg::status_t return_extent(ref pool_t p,
                                                         input longint unsigned start,
                                                         input longint unsigned cnt);
        longint unsigned maxc;
        longint unsigned stop;
        int left;
        int right;
        int slot;
        maxc  = (p.base >= p.lines) ? 0 : p.lines - p.base;
        stop  = start + cnt;
        left  = -1;
        right = -1;
        slot  = -1;
        if (start < p.base || start >= p.lines)
            return tplea_pkg::ST_BAD_START;
        if (stop > p.lines || cnt + p.total > maxc)
            return tplea_pkg::ST_OVERFLOW;
        for (int i = 0; i < tplea_pkg::MAX_EXTENTS; i++)
        begin
            if (!p.vd[i])
            begin
                if (slot < 0)
                    slot = i;
            end
            else if (left < 0 && p.st[i] + p.ln[i] == start)
                left = i;
            else if (right < 0 && p.st[i] == stop)
                right = i;
        end
        if (left >= 0 && right >= 0)
        begin
            p.ln[left] += cnt + p.ln[right];
            p.vd[right] = 0;
        end
        else if (left >= 0)
            p.ln[left] += cnt;
        else if (right >= 0)
        begin
            p.st[right] = start;
            p.ln[right] += cnt;
        end
        else
        begin
            if (slot < 0)
                return tplea_pkg::ST_TABLE_FULL;
            p.st[slot] = start;
            p.ln[slot] = cnt;
            p.vd[slot] = 1;
        end
        p.total += cnt;
        return tplea_pkg::ST_OK;
    endfunction

    function automatic tplea_pkg::rsp_t allocator_response(input tplea_pkg::req_t r);
        tplea_pkg::rsp_t o;
        longint unsigned g;
        longint unsigned red;
        o = '0;
        o.status = tplea_pkg::ST_OK;
        case (tplea_pkg::op_t'(r.op))
            tplea_pkg::OP_ALLOC:
                if (r.line_count != 0)
                begin
                    if (take_first_fit(fast_pool, 64'(r.line_count), g))
                    begin
                        o.fast_start = g[11:0];
                        o.fast_count = r.line_count[12:0];
                        o.done_count = r.line_count;
                    end
                    else
                    begin
                        red = r.line_count[0] ? 64'(tplea_pkg::ODD_RED)
                                              : 64'(tplea_pkg::EVEN_RED);
                        if (64'(r.line_count) > red &&
                            take_first_fit(slow_pool, 64'(r.line_count) - red, g))
                        begin
                            o.slow_start = g[19:0];
                            o.slow_count = 21'(64'(r.line_count) - red);
                            o.done_count = o.slow_count;
                        end
                        else
                            o.status = tplea_pkg::ST_NO_SPACE;
                    end
                end
            tplea_pkg::OP_FREE:
                if (r.free_fast_count != 0)
                begin
                    o.status = return_extent(fast_pool, 64'(r.free_fast_start),
                                             64'(r.free_fast_count));
                    if (o.status == tplea_pkg::ST_OK)
                        o.done_count = 21'(r.free_fast_count);
                end
                else if (r.free_slow_count != 0)
                begin
                    o.status = return_extent(slow_pool, 64'(r.free_slow_start),
                                             64'(r.free_slow_count));
                    if (o.status == tplea_pkg::ST_OK)
                        o.done_count = r.free_slow_count;
                end
            tplea_pkg::OP_CLEAR:
            begin
                load_pool(fast_pool, 64'(fast_base_reg) + 64'(tplea_pkg::COMMON_LINES));
                load_pool(slow_pool, 64'(slow_base_reg));
            end
            default: ;
        endcase
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        tplea_pkg::rsp_t e;
        if (!rst_n)
        begin
            fast_pool.lines = 64'(tplea_pkg::FAST_LINES);
            slow_pool.lines = 64'(tplea_pkg::SLOW_LINES);
            for (int i = 0; i < tplea_pkg::MAX_EXTENTS; i++)
            begin
                fast_pool.vd[i] = 0;
                slow_pool.vd[i] = 0;
            end
            fast_pool.total = 0;
            slow_pool.total = 0;
            fast_pool.base  = 0;
            slow_pool.base  = 0;
            fast_base_reg   = '0;
            slow_base_reg   = '0;
            expected_rsps.delete();
            fail_count   = 0;
            pending      = 0;
            results_seen = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == tplea_pkg::CFG_FAST_BASE)
                    fast_base_reg = cfg_data[11:0];
                else
                    slow_base_reg = cfg_data;
            end
            if (req_valid && !req_stall)
                expected_rsps.push_back(allocator_response(req));
            if (rsp_valid && !rsp_stall)
            begin
                results_seen++;
                if (expected_rsps.size() == 0)
                begin
                    $error("result transfer with nothing expected");
                    fail_count++;
                end
                else
                begin
                    e = expected_rsps.pop_front();
                    if (rsp.status !== e.status)
                    begin
                        $error("status: expected %0d, got %0d", e.status, rsp.status);
                        fail_count++;
                    end
                    if (rsp.fast_start !== e.fast_start)
                    begin
                        $error("fast_start: expected %0d, got %0d", e.fast_start,
                               rsp.fast_start);
                        fail_count++;
                    end
                    if (rsp.fast_count !== e.fast_count)
                    begin
                        $error("fast_count: expected %0d, got %0d", e.fast_count,
                               rsp.fast_count);
                        fail_count++;
                    end
                    if (rsp.slow_start !== e.slow_start)
                    begin
                        $error("slow_start: expected %0d, got %0d", e.slow_start,
                               rsp.slow_start);
                        fail_count++;
                    end
                    if (rsp.slow_count !== e.slow_count)
                    begin
                        $error("slow_count: expected %0d, got %0d", e.slow_count,
                               rsp.slow_count);
                        fail_count++;
                    end
                    if (rsp.done_count !== e.done_count)
                    begin
                        $error("done_count: expected %0d, got %0d", e.done_count,
                               rsp.done_count);
                        fail_count++;
                    end
                end
            end
            pending = expected_rsps.size();
        end
    end
endmodule
`default_nettype wire

[tb/sv/tb_two_pool_line_extent_allocator.sv]
// Testbench top for the two-pool line extent allocator: stimulus, idling phases and verdict.
`default_nettype none
module tb_two_pool_line_extent_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 20000;

    logic            clk;
    logic            rst_n;
    logic            req_valid;
    logic            req_stall;
    tplea_pkg::req_t req;
    logic            rsp_valid;
    logic            rsp_stall;
    tplea_pkg::rsp_t rsp;
    logic            cfg_we;
    logic            cfg_index;
    logic [19:0]     cfg_data;
    int              fail_count;
    int              pending;
    int              results_seen;
    int              send_idle_pct;
    int              stall_pct;
    int              quiet_cycles;
    int              sent_items;
    tplea_pkg::req_t held_reqs [8];
    int              held_count;
    logic [2:0]      held_wr;

    two_pool_line_extent_allocator DUT (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req(req),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    tplea_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req(req),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending), .results_seen(results_seen)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
        rsp_stall <= ($urandom_range(99) < stall_pct);

    // The watchdog ends the run when nothing transfers for too long.
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || !rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("timeout with %0d results outstanding", pending);
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic tplea_pkg::req_t make_alloc(input int unsigned cnt);
        tplea_pkg::req_t r;
        r = '0;
        r.op = tplea_pkg::OP_ALLOC;
        r.line_count = 21'(cnt);
        return r;
    endfunction

    function automatic tplea_pkg::req_t make_free(input bit to_fast, input int unsigned start,
                                                  input int unsigned cnt);
        tplea_pkg::req_t r;
        r = '0;
        r.op = tplea_pkg::OP_FREE;
        if (to_fast)
        begin
            r.free_fast_start = 12'(start);
            r.free_fast_count = 13'(cnt);
        end
        else
        begin
            r.free_slow_start = 20'(start);
            r.free_slow_count = 21'(cnt);
        end
        return r;
    endfunction

    function automatic tplea_pkg::req_t make_clear();
        tplea_pkg::req_t r;
        r = '0;
        r.op = tplea_pkg::OP_CLEAR;
        return r;
    endfunction

    // Recent grants are kept so that later frees give them back and the tables merge.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            held_count <= 0;
            held_wr    <= '0;
        end
        else if (rsp_valid && !rsp_stall && rsp.status == tplea_pkg::ST_OK
                 && (rsp.fast_count != '0 || rsp.slow_count != '0))
        begin
            held_reqs[held_wr] <= (rsp.fast_count != '0)
                ? make_free(1'b1, 32'(rsp.fast_start), 32'(rsp.fast_count))
                : make_free(1'b0, 32'(rsp.slow_start), 32'(rsp.slow_count));
            held_wr <= held_wr + 3'd1;
            if (held_count < 8)
                held_count <= held_count + 1;
        end
    end

    task automatic send_request(input tplea_pkg::req_t r);
        if ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        sent_items++;
    endtask

    // Waits for every outstanding result and for the block to settle before a write.
    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_bases(input int unsigned fast_base, input int unsigned slow_base);
        cfg_we    <= 1'b1;
        cfg_index <= tplea_pkg::CFG_FAST_BASE;
        cfg_data  <= 20'(fast_base);
        @(posedge clk);
        cfg_index <= tplea_pkg::CFG_SLOW_BASE;
        cfg_data  <= 20'(slow_base);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Mostly sensible sizes, with rare full-width and noisy fields.
    function automatic tplea_pkg::req_t random_request();
        tplea_pkg::req_t r;
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 45)
        begin
            if ($urandom_range(9) == 0)
                r = make_alloc($urandom_range(2097151));
            else if ($urandom_range(3) == 0)
                r = make_alloc($urandom_range(8191));
            else
                r = make_alloc($urandom_range(600));
        end
        else if (sel < 70)
            r = make_free(1, $urandom_range(4095),
                          ($urandom_range(9) == 0) ? $urandom_range(8191)
                                                   : $urandom_range(1, 300));
        else if (sel < 93)
            r = make_free(0, $urandom_range(1048575),
                          ($urandom_range(9) == 0) ? $urandom_range(2097151)
                                                   : $urandom_range(1, 5000));
        else if (sel < 97)
            r = make_clear();
        else
        begin
            r = tplea_pkg::req_t'($bits(tplea_pkg::req_t)'({$urandom, $urandom, $urandom}));
            r.op = tplea_pkg::OP_NONE;
        end
        // Stray bits in unused fields must not matter.
        if ($urandom_range(3) == 0)
        begin
            if (r.op == tplea_pkg::OP_ALLOC)
            begin
                r.free_fast_start = 12'($urandom);
                r.free_slow_start = 20'($urandom);
                r.free_slow_count = 21'($urandom);
            end
            else
                r.line_count = 21'($urandom);
        end
        return r;
    endfunction

    initial
    begin
        int unsigned fast_bases [4];
        int unsigned slow_bases [4];
        tplea_pkg::req_t r;
        fast_bases = '{0, 4088, 1234, 4086};
        slow_bases = '{0, 1048575, 700000, 1048570};
        rst_n         = 1'b0;
        req_valid     = 1'b0;
        req           = '0;
        cfg_we        = 1'b0;
        cfg_index     = tplea_pkg::CFG_FAST_BASE;
        cfg_data      = '0;
        send_idle_pct = 0;
        stall_pct     = 0;
        sent_items    = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: requests before any clear, then field extremes after one.
        send_request(make_alloc(0));
        send_request(make_alloc(2097151));
        send_request(make_free(1, 4095, 8191));
        send_request(make_free(0, 0, 0));
        drain();
        write_bases(0, 0);
        send_request(make_clear());
        send_request(make_alloc(0));
        send_request(make_alloc(1));
        send_request(make_alloc(4087));
        send_request(make_alloc(4));
        send_request(make_alloc(5));
        send_request(make_alloc(6));
        send_request(make_alloc(7));
        send_request(make_alloc(1048576));
        send_request(make_free(1, 8, 1));
        send_request(make_free(1, 9, 1));
        send_request(make_free(1, 4095, 2));
        send_request(make_free(1, 4095, 1));
        send_request(make_free(1, 10, 4096));
        send_request(make_free(0, 0, 2097151));
        send_request(make_free(0, 1048575, 1));
        r = tplea_pkg::req_t'($bits(tplea_pkg::req_t)'({$urandom, $urandom, $urandom}));
        r.op = tplea_pkg::OP_NONE;
        send_request(r);
        // Fill the fast table with separate holes until it overflows.
        drain();
        send_request(make_clear());
        send_request(make_alloc(4000));
        for (int i = 0; i < 17; i++)
            send_request(make_free(1, 20 + 4 * i, 1));

        for (int ph = 0; ph < 8; ph++)
        begin
            drain();
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 68; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 68; end
                default: begin send_idle_pct = 21; stall_pct = 21; end
            endcase
            write_bases(ph < 4 ? fast_bases[ph[1:0]] : $urandom_range(4095),
                        ph < 4 ? slow_bases[ph[1:0]] : $urandom_range(1048575));
            send_request(make_clear());
            for (int n = 0; n < 70; n++)
            begin
                // Half the requests give back a recent grant so the tables merge and split.
                if (held_count != 0 && $urandom_range(1) == 0)
                    r = held_reqs[3'($urandom_range(held_count - 1))];
                else
                    r = random_request();
                send_request(r);
            end
        end

        drain();
        $display("Sent %0d requests and checked %0d results over eight base settings",
                 sent_items, results_seen);
        $display("and four idling phases, including table overflow and merges.");
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
`default_nettype wire
